/* sv/nfa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, constants and helpers for the NFA word acceptor.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int MAX_STATES      = 16;
    localparam int MAX_TRANSITIONS = 64;
    localparam int SYMBOL_BITS     = 8;

    localparam int STATE_W = 4;
    localparam int NUM_W   = 5;
    localparam int SET_W   = 16;
    localparam int SYM_W   = 8;
    localparam int ADDR_W  = $clog2(MAX_TRANSITIONS);
    localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1);
    localparam int CFG_W   = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_SYMBOL = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_NUM_STATES = 2'd0,
        REG_START      = 2'd1,
        REG_FINAL      = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_CLOSE,
        ST_FINISH
    } st_t;

    typedef struct packed {
        logic [STATE_W-1:0]     src;
        logic [STATE_W-1:0]     dst;
        logic                   eps;
        logic [SYMBOL_BITS-1:0] label;
    } tt_entry_t;

    typedef struct packed {
        logic                   closing;
        logic                   symbol_op;
        logic [SYMBOL_BITS-1:0] sym;
        logic [NUM_W-1:0]       num_states;
    } eval_ctl_t;

    function automatic logic state_bad(input logic [STATE_W-1:0] s,
                                       input logic [NUM_W-1:0] n);
        return {1'b0, s} >= n;
    endfunction

    function automatic logic cfg_bad(input logic [NUM_W-1:0] n,
                                     input logic [STATE_W-1:0] start,
                                     input logic [SET_W-1:0] fmask);
        logic [SET_W-1:0] inuse;
        for (int i = 0; i < SET_W; i++)
        begin
            inuse[i] = NUM_W'(i) < n;
        end
        return (n == '0) || (n > NUM_W'(MAX_STATES)) || state_bad(start, n)
            || ((fmask & ~inuse) != '0);
    endfunction

endpackage

/* sv/nfa_if.sv */
// ----------------------------------------------------------------------------
// nfa_if
// Handshake channels of the NFA word acceptor: input words, results, config.
// ----------------------------------------------------------------------------
interface nfa_in_if;
    import nfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [STATE_W-1:0] source_state;
    logic [STATE_W-1:0] target_state;
    logic               is_epsilon;
    logic [SYM_W-1:0]   symbol;

    modport source (output valid, op, source_state, target_state, is_epsilon, symbol,
                    input ready);
    modport sink   (input valid, op, source_state, target_state, is_epsilon, symbol,
                    output ready);
endinterface

interface nfa_out_if;
    import nfa_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             accepted;
    logic [SET_W-1:0] active_set;
    logic             set_empty;

    modport source (output valid, status, accepted, active_set, set_empty,
                    input ready);
    modport sink   (input valid, status, accepted, active_set, set_empty,
                    output ready);
endinterface

interface nfa_cfg_if;
    import nfa_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       addr;
    logic [CFG_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* sv/nfa_table.sv */
// ----------------------------------------------------------------------------
// nfa_table
// Transition table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfa_table
    import nfa_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  tt_entry_t         wdata,
    input  logic [ADDR_W-1:0] raddr,
    output tt_entry_t         rdata
);

    tt_entry_t mem [MAX_TRANSITIONS];
    tt_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/nfa_eval.sv */
// ----------------------------------------------------------------------------
// nfa_eval
// Shared per-transition unit: labelled move or epsilon step, range check.
// ----------------------------------------------------------------------------
module nfa_eval
    import nfa_pkg::*;
(
    input  eval_ctl_t        ctl,
    input  tt_entry_t        entry,
    input  logic [SET_W-1:0] src_set,
    input  logic [SET_W-1:0] acc_set,
    output logic [SET_W-1:0] acc_out,
    output logic             grew,
    output logic             bad
);

    logic             hit;
    logic [SET_W-1:0] dst_bit;

    always_comb
    begin
        dst_bit = SET_W'(1) << entry.dst;
        if (ctl.closing)
        begin
            hit = entry.eps && src_set[entry.src];
        end
        else
        begin
            hit = ctl.symbol_op && !entry.eps && (entry.label == ctl.sym)
                && src_set[entry.src];
        end
        acc_out = hit ? (acc_set | dst_bit) : acc_set;
        grew    = hit && !acc_set[entry.dst];
        bad     = state_bad(entry.src, ctl.num_states)
               || state_bad(entry.dst, ctl.num_states);
    end

endmodule

/* sv/nfa_word_acceptor.sv */
// ----------------------------------------------------------------------------
// nfa_word_acceptor
// NFA simulation over a byte stream with epsilon closure on a stored table.
// ----------------------------------------------------------------------------
// Load and clear words go from accept straight to the result stage.
// Begin and symbol words: a move pass over the stored transitions, then P epsilon
// passes (one more than the passes that grow the set, at most 16), each read via
// the single table read port and the shared unit; bad automata skip the closure.
// One word in flight at a time; the result register frees the input side.
// Reset clears control, counters, the current set and configuration; table is unwritten.
module nfa_word_acceptor
    import nfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    nfa_in_if.sink    items,
    nfa_out_if.source results,
    nfa_cfg_if.sink   cfg
);

    st_t                    state_reg, state_next;
    logic [NUM_W-1:0]       num_states_reg;
    logic [STATE_W-1:0]     start_reg;
    logic [SET_W-1:0]       final_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   sym_op_reg, sym_op_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [SET_W-1:0]       cur_reg, cur_next;
    logic [SET_W-1:0]       work_reg, work_next;
    logic                   changed_reg, changed_next;
    logic                   bad_reg, bad_next;
    status_t                status_reg, status_next;
    logic                   out_vld_reg, out_vld_next;
    status_t                out_status_reg, out_status_next;
    logic [SET_W-1:0]       out_set_reg, out_set_next;
    logic                   out_acc_reg, out_acc_next;

    logic       in_fire;
    logic       out_free;
    logic       pass_done;
    op_t        op_in;
    logic       we;
    tt_entry_t  wdata;
    tt_entry_t  rdata;
    eval_ctl_t  ctl;
    logic [SET_W-1:0] ev_src, ev_acc, ev_out;
    logic       ev_grew, ev_bad;

    assign op_in     = op_t'(items.op);
    assign in_fire   = items.valid && items.ready;
    assign out_free  = !out_vld_reg || results.ready;
    assign pass_done = (idx_reg >= count_reg) && !rd_vld_reg;

    assign wdata.src   = items.source_state;
    assign wdata.dst   = items.target_state;
    assign wdata.eps   = items.is_epsilon;
    assign wdata.label = items.symbol[SYMBOL_BITS-1:0];

    nfa_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign ctl.closing    = (state_reg == ST_CLOSE);
    assign ctl.symbol_op  = sym_op_reg;
    assign ctl.sym        = sym_reg;
    assign ctl.num_states = num_states_reg;
    assign ev_src = (state_reg == ST_CLOSE) ? work_reg : cur_reg;
    assign ev_acc = work_reg;

    nfa_eval u_eval (
        .ctl     (ctl),
        .entry   (rdata),
        .src_set (ev_src),
        .acc_set (ev_acc),
        .acc_out (ev_out),
        .grew    (ev_grew),
        .bad     (ev_bad)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op_in == OP_BEGIN || op_in == OP_SYMBOL)
                        state_next = ST_MOVE;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_MOVE:
            begin
                if (pass_done)
                    state_next = (bad_reg ? ST_FINISH : ST_CLOSE);
            end
            ST_CLOSE:
            begin
                if (pass_done && !changed_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        sym_op_next     = sym_op_reg;
        sym_next        = sym_reg;
        cur_next        = cur_reg;
        work_next       = work_reg;
        changed_next    = changed_reg;
        bad_next        = bad_reg;
        status_next     = status_reg;
        out_vld_next    = out_vld_reg && !results.ready;
        out_status_next = out_status_reg;
        out_set_next    = out_set_reg;
        out_acc_next    = out_acc_reg;
        we              = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = STAT_OK;
                    idx_next    = '0;
                    sym_op_next = (op_in == OP_SYMBOL);
                    sym_next    = items.symbol[SYMBOL_BITS-1:0];
                    bad_next    = cfg_bad(num_states_reg, start_reg, final_reg);
                    work_next   = (op_in == OP_BEGIN) ? (SET_W'(1) << start_reg) : '0;
                    unique case (op_in)
                        OP_LOAD:
                        begin
                            if (state_bad(items.source_state, num_states_reg)
                                || state_bad(items.target_state, num_states_reg))
                                status_next = STAT_RANGE;
                            else if (count_reg >= CNT_W'(MAX_TRANSITIONS))
                                status_next = STAT_FULL;
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR: count_next = '0;
                        OP_BEGIN, OP_SYMBOL: ;
                        default: ;
                    endcase
                end
            end
            ST_MOVE, ST_CLOSE:
            begin
                if (idx_reg < count_reg)
                begin
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    work_next = ev_out;
                    if (state_reg == ST_MOVE)
                        bad_next = bad_reg || ev_bad;
                    else
                        changed_next = changed_reg || ev_grew;
                end
                if (pass_done)
                begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                    if (state_reg == ST_MOVE && bad_reg)
                    begin
                        status_next = STAT_INVALID;
                        cur_next    = '0;
                    end
                    else if (state_reg == ST_CLOSE && !changed_reg)
                        cur_next = work_reg;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = status_reg;
                    out_set_next    = cur_reg;
                    out_acc_next    = (cur_reg & final_reg) != '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_states_reg <= '0;
            start_reg      <= '0;
            final_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            cur_reg        <= '0;
            changed_reg    <= 1'b0;
            bad_reg        <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            cur_reg     <= cur_next;
            changed_reg <= changed_next;
            bad_reg     <= bad_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    REG_NUM_STATES: num_states_reg <= cfg.data[NUM_W-1:0];
                    REG_START:      start_reg      <= cfg.data[STATE_W-1:0];
                    REG_FINAL:      final_reg      <= cfg.data[SET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_op_reg     <= sym_op_next;
        sym_reg        <= sym_next;
        work_reg       <= work_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_set_reg    <= out_set_next;
        out_acc_reg    <= out_acc_next;
    end

    assign items.ready        = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign results.valid      = out_vld_reg;
    assign results.status     = out_status_reg;
    assign results.active_set = out_set_reg;
    assign results.accepted   = out_acc_reg;
    assign results.set_empty  = (out_set_reg == '0);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TRANSITIONS))
        else $error("transition count beyond table depth");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (idx_reg != '0) && (state_reg == ST_MOVE || state_reg == ST_CLOSE))
        else $error("table data valid without an issued read");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> results.valid && state_reg == ST_IDLE)
        else $error("finished word not moved to result register");

    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == STAT_INVALID) |-> results.set_empty)
        else $error("invalid automaton result with active states");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NFA word acceptor. A directed table covers
// reset state, range and invalid-automaton errors and a small hand-built
// automaton; random phases then reconfigure the block, load tables (some of
// them up to and past full) and run begin/symbol sequences with noise words.
// Each result is checked against a bench NFA predictor or a pinned value, with
// random idling on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import nfa_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 20000;
    localparam int WORD_TARGET   = 530;

    typedef struct packed {
        op_t                op;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic               eps;
        logic [SYM_W-1:0]   sym;
    } word_t;

    typedef struct packed {
        status_t          status;
        logic             accepted;
        logic [SET_W-1:0] active_set;
        logic             set_empty;
    } result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        word_t            word;
        cfg_reg_t         cfg_index;
        logic [CFG_W-1:0] value;
        logic             pinned;
        result_t          want;
    } row_t;

    localparam word_t   NO_WORD   = '{OP_CLEAR, 4'd0, 4'd0, 1'b0, 8'h00};
    localparam result_t EMPTY_OK  = '{STAT_OK, 1'b0, 16'h0000, 1'b1};
    localparam result_t EMPTY_RNG = '{STAT_RANGE, 1'b0, 16'h0000, 1'b1};
    localparam result_t EMPTY_INV = '{STAT_INVALID, 1'b0, 16'h0000, 1'b1};

    localparam int DIRECTED_ROWS = 35;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'hFF}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_WORD, '{OP_LOAD, 4'd15, 4'd15, 1'b1, 8'hFF}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_RNG},
        '{ROW_WORD, '{OP_CLEAR, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_NUM_STATES, 16'd16, 1'b0, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_START, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_FINAL, 16'h8000, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd15, 4'd15, 1'b1, 8'hFF}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd0, 4'd1, 1'b0, 8'h61}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd1, 4'd2, 1'b1, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd2, 4'd1, 1'b0, 8'h62}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd2, 4'd15, 1'b0, 8'h63}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_LOAD, 4'd0, 4'd3, 1'b1, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h61}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h62}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h63}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h7A}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_NUM_STATES, 16'd4, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_WORD, '{OP_LOAD, 4'd3, 4'd4, 1'b0, 8'h10}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_RNG},
        '{ROW_WORD, '{OP_LOAD, 4'd15, 4'd0, 1'b1, 8'h20}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_RNG},
        '{ROW_WORD, '{OP_CLEAR, 4'd15, 4'd15, 1'b1, 8'hFF}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_START, 16'd3, 1'b0, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_FINAL, 16'h0008, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK},
        '{ROW_CFG, NO_WORD, REG_NUM_STATES, 16'd31, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_CFG, NO_WORD, REG_NUM_STATES, 16'd2, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_SYMBOL, 4'd0, 4'd0, 1'b0, 8'h55}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_CFG, NO_WORD, REG_START, 16'd1, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b1, EMPTY_INV},
        '{ROW_CFG, NO_WORD, REG_FINAL, 16'h0002, 1'b0, EMPTY_OK},
        '{ROW_WORD, '{OP_BEGIN, 4'd0, 4'd0, 1'b0, 8'h00}, REG_NUM_STATES, 16'd0, 1'b0, EMPTY_OK}
    };

    logic clk = 1'b0;
    logic rst_n;

    nfa_in_if  word_ch ();
    nfa_out_if result_ch ();
    nfa_cfg_if reg_ch ();

    nfa_word_acceptor uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (word_ch),
        .results (result_ch),
        .cfg     (reg_ch)
    );

    // bench copy of the automaton
    logic [STATE_W-1:0] tbl_src [MAX_TRANSITIONS];
    logic [STATE_W-1:0] tbl_dst [MAX_TRANSITIONS];
    logic               tbl_eps [MAX_TRANSITIONS];
    logic [SYM_W-1:0]   tbl_label [MAX_TRANSITIONS];
    int                 tbl_count = 0;
    logic [SET_W-1:0]   active = '0;
    logic [NUM_W-1:0]   cfg_num = '0;
    logic [STATE_W-1:0] cfg_start = '0;
    logic [SET_W-1:0]   cfg_final = '0;

    result_t expected_results [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      words_sent   = 0;
    int      quiet_cycles = 0;
    bit      calm         = 1'b0;
    bit      hold_results = 1'b0;

    always #4 clk = ~clk;

    task automatic note_mismatch(input string field, input logic [SET_W-1:0] got,
                                 input logic [SET_W-1:0] want);
        $display("mismatch, result %0d: %s got %0h expected %0h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    function automatic logic automaton_sound();
        int i;
        if (cfg_num == '0 || cfg_num > NUM_W'(MAX_STATES))
            return 1'b0;
        if ({1'b0, cfg_start} >= cfg_num)
            return 1'b0;
        for (i = 0; i < SET_W; i++)
        begin
            if (cfg_final[i] && i >= int'(cfg_num))
                return 1'b0;
        end
        for (i = 0; i < tbl_count; i++)
        begin
            if ({1'b0, tbl_src[i]} >= cfg_num || {1'b0, tbl_dst[i]} >= cfg_num)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [SET_W-1:0] spread_epsilon(input logic [SET_W-1:0] seed);
        logic [SET_W-1:0] grown;
        logic [SET_W-1:0] prior;
        int               i;
        grown = seed;
        do
        begin
            prior = grown;
            for (i = 0; i < tbl_count; i++)
            begin
                if (tbl_eps[i] && grown[tbl_src[i]])
                    grown[tbl_dst[i]] = 1'b1;
            end
        end
        while (grown != prior);
        return grown;
    endfunction

    function automatic result_t advance_nfa(input word_t w);
        result_t          r;
        logic [SET_W-1:0] moved;
        int               i;
        r.status = STAT_OK;
        case (w.op)
            OP_LOAD:
            begin
                if ({1'b0, w.src} >= cfg_num || {1'b0, w.dst} >= cfg_num)
                    r.status = STAT_RANGE;
                else if (tbl_count >= MAX_TRANSITIONS)
                    r.status = STAT_FULL;
                else
                begin
                    tbl_src[tbl_count]   = w.src;
                    tbl_dst[tbl_count]   = w.dst;
                    tbl_eps[tbl_count]   = w.eps;
                    tbl_label[tbl_count] = w.sym;
                    tbl_count++;
                end
            end
            OP_CLEAR:
                tbl_count = 0;
            default:
            begin
                if (!automaton_sound())
                begin
                    r.status = STAT_INVALID;
                    active   = '0;
                end
                else if (w.op == OP_BEGIN)
                    active = spread_epsilon(SET_W'(1) << cfg_start);
                else
                begin
                    moved = '0;
                    for (i = 0; i < tbl_count; i++)
                    begin
                        if (!tbl_eps[i] && tbl_label[i] == w.sym && active[tbl_src[i]])
                            moved[tbl_dst[i]] = 1'b1;
                    end
                    active = spread_epsilon(moved);
                end
            end
        endcase
        r.accepted   = |(active & cfg_final);
        r.active_set = active;
        r.set_empty  = (active == '0);
        return r;
    endfunction

    function automatic logic [STATE_W-1:0] pick_state(input logic [NUM_W-1:0] n);
        if (n == '0 || $urandom_range(0, 9) == 0)
            return STATE_W'($urandom_range(0, 15));
        if (n > NUM_W'(MAX_STATES))
            return STATE_W'($urandom_range(0, 15));
        return STATE_W'($urandom_range(0, int'(n) - 1));
    endfunction

    function automatic logic [SYM_W-1:0] pick_label(input logic [SYM_W-1:0] base);
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom_range(0, 255));
        return base + SYM_W'($urandom_range(0, 3));
    endfunction

    task automatic send_word(input word_t w, input logic pinned, input result_t want);
        result_t got;
        int      pick;
        word_ch.valid        <= 1'b1;
        word_ch.op           <= w.op;
        word_ch.source_state <= w.src;
        word_ch.target_state <= w.dst;
        word_ch.is_epsilon   <= w.eps;
        word_ch.symbol       <= w.sym;
        do
            @(posedge clk);
        while (word_ch.ready !== 1'b1);
        got = advance_nfa(w);
        expected_results.insert(expected_results.size(), pinned ? want : got);
        words_sent++;
        if (!calm)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 55)
            begin
                word_ch.valid <= 1'b0;
                repeat (pick < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40))
                    @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value,
                             input logic last);
        reg_ch.valid <= 1'b1;
        reg_ch.addr  <= idx;
        reg_ch.data  <= value;
        do
            @(posedge clk);
        while (reg_ch.ready !== 1'b1);
        case (idx)
            REG_NUM_STATES: cfg_num   = value[NUM_W-1:0];
            REG_START:      cfg_start = value[STATE_W-1:0];
            REG_FINAL:      cfg_final = value[SET_W-1:0];
            default:        ;
        endcase
        if (last)
            reg_ch.valid <= 1'b0;
    endtask

    // hold the word channel until every result is back
    task automatic drain_results();
        word_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int span;
        int pick;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            else if (calm)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    result_ch.ready <= 1'b1;
                    span = $urandom_range(1, 8);
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    span = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
                end
                repeat (span)
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                note_mismatch("result with nothing outstanding", result_ch.active_set, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.status !== want.status)
                    note_mismatch("status", SET_W'(result_ch.status), SET_W'(want.status));
                if (result_ch.accepted !== want.accepted)
                    note_mismatch("accepted", SET_W'(result_ch.accepted),
                                  SET_W'(want.accepted));
                if (result_ch.active_set !== want.active_set)
                    note_mismatch("active_set", result_ch.active_set, want.active_set);
                if (result_ch.set_empty !== want.set_empty)
                    note_mismatch("set_empty", SET_W'(result_ch.set_empty),
                                  SET_W'(want.set_empty));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((word_ch.valid === 1'b1 && word_ch.ready === 1'b1)
            || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            || (reg_ch.valid === 1'b1 && reg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int               k;
        int               n;
        int               g;
        int               phase;
        int               loads;
        int               pick;
        bit               fill;
        logic [NUM_W-1:0] num;
        logic [STATE_W-1:0] start;
        logic [SET_W-1:0] fmask;
        logic [SET_W-1:0] inuse;
        logic [SYM_W-1:0] base;
        word_t            w;
        row_t             row;

        rst_n                <= 1'b0;
        word_ch.valid        <= 1'b0;
        word_ch.op           <= OP_LOAD;
        word_ch.source_state <= '0;
        word_ch.target_state <= '0;
        word_ch.is_epsilon   <= 1'b0;
        word_ch.symbol       <= '0;
        reg_ch.valid         <= 1'b0;
        reg_ch.addr          <= REG_NUM_STATES;
        reg_ch.data          <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (row.kind == ROW_CFG)
            begin
                if (DIRECTED[k - 1].kind == ROW_WORD)
                    drain_results();
                write_reg(row.cfg_index, row.value, DIRECTED[k + 1].kind == ROW_WORD);
            end
            else
                send_word(row.word, row.pinned, row.want);
        end

        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            drain_results();
            fill = (phase % 7 == 2);
            calm = (phase == 1) || ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (fill || (pick >= 15 && pick < 30))
                num = NUM_W'(MAX_STATES);
            else if (pick < 8)
                num = '0;
            else if (pick < 15)
                num = NUM_W'($urandom_range(17, 31));
            else
                num = NUM_W'($urandom_range(1, 16));
            if (num != '0 && num <= NUM_W'(MAX_STATES) && $urandom_range(0, 9) != 0)
                start = STATE_W'($urandom_range(0, int'(num) - 1));
            else
                start = STATE_W'($urandom_range(0, 15));
            inuse = (num >= NUM_W'(16)) ? '1 : (SET_W'(1) << num) - SET_W'(1);
            fmask = SET_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) != 0)
                fmask = fmask & inuse;
            write_reg(REG_NUM_STATES, CFG_W'(num), 1'b0);
            write_reg(REG_START, CFG_W'(start), 1'b0);
            write_reg(REG_FINAL, fmask, 1'b1);

            // stall the result side while words keep coming
            if (phase == 1)
                hold_results = 1'b1;

            base = SYM_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0)
            begin
                w = '{OP_CLEAR, pick_state(num), pick_state(num),
                      1'($urandom_range(0, 1)), pick_label(base)};
                send_word(w, 1'b0, EMPTY_OK);
            end
            loads = fill ? 80 : $urandom_range(1, 16);
            for (n = 0; n < loads; n++)
            begin
                w = '{OP_LOAD, pick_state(num), pick_state(num),
                      ($urandom_range(0, 9) < 3), pick_label(base)};
                send_word(w, 1'b0, EMPTY_OK);
            end
            for (g = $urandom_range(2, 8); g > 0; g--)
            begin
                w = '{OP_BEGIN, pick_state(num), pick_state(num),
                      1'($urandom_range(0, 1)), pick_label(base)};
                send_word(w, 1'b0, EMPTY_OK);
                for (n = $urandom_range(1, 6); n > 0; n--)
                begin
                    if ($urandom_range(0, 9) == 0)
                        w = word_t'($bits(word_t)'($urandom));
                    else
                        w = '{OP_SYMBOL, pick_state(num), pick_state(num),
                              1'($urandom_range(0, 1)), pick_label(base)};
                    send_word(w, 1'b0, EMPTY_OK);
                end
            end
            phase++;
        end

        calm = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", SET_W'(0),
                          SET_W'(expected_results.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* nfa_word_acceptor.f */
sv/nfa_pkg.sv
sv/nfa_if.sv
sv/nfa_table.sv
sv/nfa_eval.sv
sv/nfa_word_acceptor.sv
test/testbench.sv
